// ===== sv/aexs_pkg.sv =====
// Shared types and codes for the ARM execute stage.
// Holds the opcode, shift, condition and class codes and the result record.
// No dependencies.
`default_nettype none

package aexs_pkg;

    localparam logic [1:0] CLS_DATA   = 2'd0;
    localparam logic [1:0] CLS_MUL    = 2'd1;
    localparam logic [1:0] CLS_MEM    = 2'd2;
    localparam logic [1:0] CLS_BRANCH = 2'd3;

    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_CS = 4'd2;
    localparam logic [3:0] COND_CC = 4'd3;
    localparam logic [3:0] COND_MI = 4'd4;
    localparam logic [3:0] COND_PL = 4'd5;
    localparam logic [3:0] COND_VS = 4'd6;
    localparam logic [3:0] COND_VC = 4'd7;
    localparam logic [3:0] COND_HI = 4'd8;
    localparam logic [3:0] COND_LS = 4'd9;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;

    localparam logic [3:0] MUL_TAG    = 4'b1001;
    localparam logic [1:0] MEM_TAG    = 2'b01;
    localparam logic [2:0] BR_TAG     = 3'b101;
    localparam logic [1:0] DP_TAG     = 2'b00;
    localparam logic [2:0] BLOCK_TAG  = 3'b100;
    localparam logic [1:0] COPROC_TAG = 2'b11;
    localparam logic [7:0] AMT_32     = 8'd32;

    typedef struct packed {
        logic [31:0] result_value;
        logic [31:0] updated_base;
        logic [1:0]  op_class;
        logic        cond_passed;
        logic        writes_result;
        logic [3:0]  flags_out;
    } t_exec_result;

endpackage

`default_nettype wire

// ===== sv/aexs_shifter.sv =====
// Barrel shifter: LSL, LSR, ASR, ROR and RRX with ARM carry-out rules.
// Depends on aexs_pkg for the shift type codes.
`default_nettype none

module aexs_shifter
    import aexs_pkg::*;
(
    input  wire logic [31:0] i_value,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_amount,
    input  wire logic        i_rrx,
    input  wire logic        i_carry,
    output logic [31:0]      o_value,
    output logic             o_carry
);

    logic [32:0] w_lsl;
    logic [32:0] w_lsr;
    logic [32:0] w_asr;
    logic [63:0] w_ror;
    logic        w_big;
    logic        w_is32;
    logic        w_sign;

    assign w_lsl  = {1'b0, i_value} << i_amount[4:0];
    assign w_lsr  = {i_value, 1'b0} >> i_amount[4:0];
    assign w_asr  = $signed({i_value, 1'b0}) >>> i_amount[4:0];
    assign w_ror  = {i_value, i_value} >> i_amount[4:0];
    assign w_big  = (i_amount[7:5] != 3'd0);
    assign w_is32 = (i_amount == AMT_32);
    assign w_sign = i_value[31];

    always_comb begin
        o_value = i_value;
        o_carry = i_carry;
        if (i_rrx) begin
            o_value = {i_carry, i_value[31:1]};
            o_carry = i_value[0];
        end else if (i_amount != 8'd0) begin
            case (i_kind)
                SHIFT_LSL: begin
                    if (!w_big) begin
                        o_value = w_lsl[31:0];
                        o_carry = w_lsl[32];
                    end else begin
                        o_value = 32'd0;
                        o_carry = w_is32 & i_value[0];
                    end
                end
                SHIFT_LSR: begin
                    if (!w_big) begin
                        o_value = w_lsr[32:1];
                        o_carry = w_lsr[0];
                    end else begin
                        o_value = 32'd0;
                        o_carry = w_is32 & w_sign;
                    end
                end
                SHIFT_ASR: begin
                    if (!w_big) begin
                        o_value = w_asr[32:1];
                        o_carry = w_asr[0];
                    end else begin
                        o_value = {32{w_sign}};
                        o_carry = w_sign;
                    end
                end
                default: begin
                    o_value = w_ror[31:0];
                    o_carry = w_ror[31];
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/aexs_core.sv =====
// Execute datapath: condition check, decode, shifter operand, ALU, multiply
// and load/store address. Depends on aexs_pkg and aexs_shifter.
`default_nettype none

module aexs_core
    import aexs_pkg::*;
(
    input  wire logic [31:0] i_instruction,
    input  wire logic [31:0] i_value_bits_19_16,
    input  wire logic [31:0] i_value_bits_15_12,
    input  wire logic [31:0] i_value_bits_11_8,
    input  wire logic [31:0] i_value_bits_3_0,
    input  wire logic [3:0]  i_flags,
    output t_exec_result     o_result
);

    logic [31:0] ir;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] vc;
    logic [31:0] vd;
    logic        fn;
    logic        fz;
    logic        fc;
    logic        fv;
    logic        w_passed;
    logic        w_is_mul;
    logic        w_is_mem;
    logic        w_is_br;
    logic        w_is_dp;
    logic [31:0] w_sh_in;
    logic [1:0]  w_sh_kind;
    logic [7:0]  w_sh_amt;
    logic        w_sh_rrx;
    logic [31:0] w_sh_out;
    logic        w_sh_c;
    logic [1:0]  w_imm_kind;
    logic [4:0]  w_imm_amt;
    logic [31:0] w_prod;
    logic [31:0] w_mul;
    logic [31:0] w_off;
    logic [31:0] w_base;
    logic [3:0]  w_op;
    logic [31:0] w_ax;
    logic [31:0] w_ay;
    logic        w_acin;
    logic [32:0] w_sum;
    logic        w_av;
    logic        w_logic;
    logic [31:0] w_lres;
    logic [31:0] w_dres;
    logic [3:0]  w_nf;

    assign ir = i_instruction;
    assign va = i_value_bits_19_16;
    assign vb = i_value_bits_15_12;
    assign vc = i_value_bits_11_8;
    assign vd = i_value_bits_3_0;
    assign {fn, fz, fc, fv} = i_flags;

    always_comb begin
        case (ir[31:28])
            COND_EQ: w_passed = fz;
            COND_NE: w_passed = !fz;
            COND_CS: w_passed = fc;
            COND_CC: w_passed = !fc;
            COND_MI: w_passed = fn;
            COND_PL: w_passed = !fn;
            COND_VS: w_passed = fv;
            COND_VC: w_passed = !fv;
            COND_HI: w_passed = fc && !fz;
            COND_LS: w_passed = !fc || fz;
            COND_GE: w_passed = (fn == fv);
            COND_LT: w_passed = (fn != fv);
            COND_GT: w_passed = !fz && (fn == fv);
            COND_LE: w_passed = fz || (fn != fv);
            COND_AL: w_passed = 1'b1;
            default: w_passed = 1'b0;
        endcase
    end

    assign w_is_mul = (ir[27:22] == 6'd0) && (ir[7:4] == MUL_TAG);
    assign w_is_mem = (ir[27:26] == MEM_TAG);
    assign w_is_br  = (ir[27:25] == BR_TAG);
    assign w_is_dp  = (ir[27:26] == DP_TAG);

    assign w_imm_kind = ir[6:5];
    assign w_imm_amt  = ir[11:7];

    always_comb begin
        w_sh_in   = vd;
        w_sh_kind = w_imm_kind;
        w_sh_amt  = {3'd0, w_imm_amt};
        w_sh_rrx  = 1'b0;
        if (w_is_dp && !w_is_mem && ir[25]) begin
            w_sh_in   = {24'd0, ir[7:0]};
            w_sh_kind = SHIFT_ROR;
            w_sh_amt  = {3'd0, ir[11:8], 1'b0};
        end else if (w_is_dp && ir[4]) begin
            w_sh_amt = vc[7:0];
        end else if (w_imm_amt == 5'd0) begin
            if (w_imm_kind == SHIFT_LSR || w_imm_kind == SHIFT_ASR) begin
                w_sh_amt = AMT_32;
            end else if (w_imm_kind == SHIFT_ROR) begin
                w_sh_rrx = 1'b1;
            end
        end
    end

    aexs_shifter u_shifter (
        .i_value  (w_sh_in),
        .i_kind   (w_sh_kind),
        .i_amount (w_sh_amt),
        .i_rrx    (w_sh_rrx),
        .i_carry  (fc),
        .o_value  (w_sh_out),
        .o_carry  (w_sh_c)
    );

    assign w_prod = vc * vd;
    assign w_mul  = w_prod + (ir[21] ? vb : 32'd0);

    assign w_off  = ir[25] ? w_sh_out : {20'd0, ir[11:0]};
    assign w_base = ir[23] ? (va + w_off) : (va - w_off);

    assign w_op = ir[24:21];

    always_comb begin
        w_ax    = va;
        w_ay    = w_sh_out;
        w_acin  = 1'b0;
        w_logic = 1'b0;
        w_lres  = 32'd0;
        case (w_op)
            OP_AND, OP_TST: begin
                w_lres  = va & w_sh_out;
                w_logic = 1'b1;
            end
            OP_EOR, OP_TEQ: begin
                w_lres  = va ^ w_sh_out;
                w_logic = 1'b1;
            end
            OP_SUB, OP_CMP: begin
                w_ay   = ~w_sh_out;
                w_acin = 1'b1;
            end
            OP_RSB: begin
                w_ax   = w_sh_out;
                w_ay   = ~va;
                w_acin = 1'b1;
            end
            OP_ADD, OP_CMN: begin
                w_acin = 1'b0;
            end
            OP_ADC: begin
                w_acin = fc;
            end
            OP_SBC: begin
                w_ay   = ~w_sh_out;
                w_acin = fc;
            end
            OP_RSC: begin
                w_ax   = w_sh_out;
                w_ay   = ~va;
                w_acin = fc;
            end
            OP_ORR: begin
                w_lres  = va | w_sh_out;
                w_logic = 1'b1;
            end
            OP_MOV: begin
                w_lres  = w_sh_out;
                w_logic = 1'b1;
            end
            OP_BIC: begin
                w_lres  = va & ~w_sh_out;
                w_logic = 1'b1;
            end
            default: begin
                w_lres  = ~w_sh_out;
                w_logic = 1'b1;
            end
        endcase
    end

    assign w_sum  = {1'b0, w_ax} + {1'b0, w_ay} + {32'd0, w_acin};
    assign w_av   = (~(w_ax[31] ^ w_ay[31])) & (w_ax[31] ^ w_sum[31]);
    assign w_dres = w_logic ? w_lres : w_sum[31:0];

    always_comb begin
        o_result               = '0;
        o_result.cond_passed   = w_passed;
        o_result.op_class      = CLS_BRANCH;
        w_nf                   = i_flags;
        if (w_is_mul) begin
            o_result.op_class      = CLS_MUL;
            o_result.result_value  = w_mul;
            o_result.writes_result = 1'b1;
            if (ir[20]) begin
                w_nf = {w_mul[31], (w_mul == 32'd0), fc, fv};
            end
        end else if (w_is_mem) begin
            o_result.op_class      = CLS_MEM;
            o_result.updated_base  = w_base;
            o_result.result_value  = ir[24] ? w_base : va;
            o_result.writes_result = 1'b1;
        end else if (w_is_br) begin
            o_result.op_class = CLS_BRANCH;
        end else if (w_is_dp) begin
            o_result.op_class      = CLS_DATA;
            o_result.result_value  = w_dres;
            o_result.writes_result = (w_op < OP_TST) || (w_op > OP_CMN);
            if (ir[20]) begin
                if (w_logic) begin
                    w_nf = {w_dres[31], (w_dres == 32'd0), w_sh_c, fv};
                end else begin
                    w_nf = {w_dres[31], (w_dres == 32'd0), w_sum[32], w_av};
                end
            end
        end
        if (!w_passed) begin
            o_result.writes_result = 1'b0;
            w_nf                   = i_flags;
        end
        o_result.flags_out = w_nf;
    end

endmodule

`default_nettype wire

// ===== sv/arm_execute_stage.sv =====
// ARM execute stage top level: input register, flag register, result register.
// Depends on aexs_pkg and aexs_core.
// Takes one instruction per cycle while o_stall is low: a transfer lands in the
// input register, and the datapath pass (shifter, ALU, multiplier, address adder)
// then writes the result register and the NZCV flag register together, so a
// following instruction sees the updated flags with no bubble. The datapath holds
// a single 32x32 multiply-accumulate. Both sides hold on stall without losing items.
`default_nettype none

module arm_execute_stage
    import aexs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_instruction,
    input  wire logic [31:0] i_value_bits_19_16,
    input  wire logic [31:0] i_value_bits_15_12,
    input  wire logic [31:0] i_value_bits_11_8,
    input  wire logic [31:0] i_value_bits_3_0,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_result_value,
    output logic [31:0]      o_updated_base,
    output logic [1:0]       o_op_class,
    output logic             o_cond_passed,
    output logic             o_writes_result,
    output logic [3:0]       o_flags_out
);

    logic         r_s1_valid;
    logic [31:0]  r_ir;
    logic [31:0]  r_va;
    logic [31:0]  r_vb;
    logic [31:0]  r_vc;
    logic [31:0]  r_vd;
    logic [3:0]   r_flags;
    logic         r_out_valid;
    t_exec_result r_out;
    t_exec_result w_core;
    logic         w_adv;
    logic         w_take;

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !w_adv;
    assign w_take  = i_valid && !o_stall;

    aexs_core u_core (
        .i_instruction      (r_ir),
        .i_value_bits_19_16 (r_va),
        .i_value_bits_15_12 (r_vb),
        .i_value_bits_11_8  (r_vc),
        .i_value_bits_3_0   (r_vd),
        .i_flags            (r_flags),
        .o_result           (w_core)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= 4'd0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_adv && r_s1_valid) begin
                r_flags <= w_core.flags_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ir <= i_instruction;
            r_va <= i_value_bits_19_16;
            r_vb <= i_value_bits_15_12;
            r_vc <= i_value_bits_11_8;
            r_vd <= i_value_bits_3_0;
        end
        if (w_adv && r_s1_valid) begin
            r_out <= w_core;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_value  = r_out.result_value;
    assign o_updated_base  = r_out.updated_base;
    assign o_op_class      = r_out.op_class;
    assign o_cond_passed   = r_out.cond_passed;
    assign o_writes_result = r_out.writes_result;
    assign o_flags_out     = r_out.flags_out;

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && w_adv) |=> $stable(r_flags))
        else $error("flags changed without a result transfer");

    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.flags_out == r_flags))
        else $error("presented flags differ from kept flags");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv && !w_core.cond_passed) |=> $stable(r_flags))
        else $error("failed condition altered flags");

    a_write_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.writes_result) |-> r_out.cond_passed)
        else $error("write flagged on failed condition");

    a_branch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.op_class == CLS_BRANCH)
            |-> (r_out.result_value == 32'd0 && r_out.updated_base == 32'd0
                 && !r_out.writes_result))
        else $error("branch class carries values");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for arm_execute_stage.
// Predicts every result from the instruction and the tracked NZCV flags.
// Checks results in order under random idle and stall. Depends on aexs_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aexs_pkg::*;

    localparam int HOLD_CYCLES   = 60;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_instruction = '0;
    logic [31:0] i_value_bits_19_16 = '0;
    logic [31:0] i_value_bits_15_12 = '0;
    logic [31:0] i_value_bits_11_8 = '0;
    logic [31:0] i_value_bits_3_0 = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_result_value;
    logic [31:0] o_updated_base;
    logic [1:0]  o_op_class;
    logic        o_cond_passed;
    logic        o_writes_result;
    logic [3:0]  o_flags_out;

    logic [3:0]   nzcv = '0;
    t_exec_result pending_results[$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           hold_req = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    arm_execute_stage uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_instruction      (i_instruction),
        .i_value_bits_19_16 (i_value_bits_19_16),
        .i_value_bits_15_12 (i_value_bits_15_12),
        .i_value_bits_11_8  (i_value_bits_11_8),
        .i_value_bits_3_0   (i_value_bits_3_0),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_value     (o_result_value),
        .o_updated_base     (o_updated_base),
        .o_op_class         (o_op_class),
        .o_cond_passed      (o_cond_passed),
        .o_writes_result    (o_writes_result),
        .o_flags_out        (o_flags_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic cond_ok(input logic [3:0] cc, input logic [3:0] f);
        logic n, z, c, v;
        {n, z, c, v} = f;
        case (cc)
            COND_EQ: return z;
            COND_NE: return !z;
            COND_CS: return c;
            COND_CC: return !c;
            COND_MI: return n;
            COND_PL: return !n;
            COND_VS: return v;
            COND_VC: return !v;
            COND_HI: return c && !z;
            COND_LS: return !c || z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return z || (n != v);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] barrel(input logic [31:0] v, input logic [1:0] kind,
                                           input logic [7:0] amt, input logic cin,
                                           output logic cout);
        logic [63:0]        wide;
        logic signed [63:0] swide;
        if (amt == 8'd0) begin
            cout = cin;
            return v;
        end
        case (kind)
            SHIFT_LSL: begin
                wide = {32'h0, v} << amt;
                cout = wide[32];
                return wide[31:0];
            end
            SHIFT_LSR: begin
                wide = {v, 32'h0} >> amt;
                cout = wide[31];
                return wide[63:32];
            end
            SHIFT_ASR: begin
                swide = {v, 32'h0};
                swide = swide >>> amt;
                cout = swide[31];
                return swide[63:32];
            end
            default: begin
                if (amt[4:0] == 5'd0) begin
                    cout = v[31];
                    return v;
                end
                wide = {v, v} >> amt[4:0];
                cout = wide[31];
                return wide[31:0];
            end
        endcase
    endfunction

    function automatic logic [31:0] imm_shift(input logic [31:0] ir, input logic [31:0] v,
                                              input logic cin, output logic cout);
        logic [7:0] amt;
        amt = {3'b000, ir[11:7]};
        if (amt == 8'd0) begin
            if (ir[6:5] == SHIFT_LSR || ir[6:5] == SHIFT_ASR) begin
                amt = AMT_32;
            end else if (ir[6:5] == SHIFT_ROR) begin
                cout = v[0];
                return {cin, v[31:1]};
            end
        end
        return barrel(v, ir[6:5], amt, cin, cout);
    endfunction

    function automatic logic [31:0] add32(input logic [31:0] x, input logic [31:0] y,
                                          input logic cin, output logic cout,
                                          output logic ovf);
        logic [32:0] s;
        s = {1'b0, x} + {1'b0, y} + {32'h0, cin};
        cout = s[32];
        ovf = (x[31] == y[31]) && (s[31] != x[31]);
        return s[31:0];
    endfunction

    function automatic t_exec_result predict_execute(input logic [31:0] ir, input logic [31:0] a,
                                                     input logic [31:0] b, input logic [31:0] c,
                                                     input logic [31:0] d);
        t_exec_result r;
        logic [3:0]   f, nf, op;
        logic         cin, passed, sc, ac, av, logic_op;
        logic [31:0]  op2, off, res;
        f = nzcv;
        nf = f;
        cin = f[1];
        passed = cond_ok(ir[31:28], f);
        r = '0;
        if (ir[27:22] == '0 && ir[7:4] == MUL_TAG) begin
            r.op_class = CLS_MUL;
            r.result_value = c * d + (ir[21] ? b : 32'h0);
            r.writes_result = 1'b1;
            if (ir[20])
                nf = {r.result_value[31], r.result_value == 32'h0, f[1:0]};
        end else if (ir[27:26] == MEM_TAG) begin
            if (ir[25])
                off = imm_shift(ir, d, cin, sc);
            else
                off = {20'h0, ir[11:0]};
            r.op_class = CLS_MEM;
            r.updated_base = ir[23] ? a + off : a - off;
            r.result_value = ir[24] ? r.updated_base : a;
            r.writes_result = 1'b1;
        end else if (ir[27:25] == BR_TAG) begin
            r.op_class = CLS_BRANCH;
        end else if (ir[27:26] == DP_TAG) begin
            op = ir[24:21];
            if (ir[25])
                op2 = barrel({24'h0, ir[7:0]}, SHIFT_ROR, {3'b000, ir[11:8], 1'b0}, cin, sc);
            else if (ir[4])
                op2 = barrel(d, ir[6:5], c[7:0], cin, sc);
            else
                op2 = imm_shift(ir, d, cin, sc);
            ac = 1'b0;
            av = 1'b0;
            logic_op = 1'b0;
            case (op)
                OP_AND, OP_TST: begin res = a & op2; logic_op = 1'b1; end
                OP_EOR, OP_TEQ: begin res = a ^ op2; logic_op = 1'b1; end
                OP_SUB, OP_CMP: res = add32(a, ~op2, 1'b1, ac, av);
                OP_RSB:         res = add32(op2, ~a, 1'b1, ac, av);
                OP_ADD, OP_CMN: res = add32(a, op2, 1'b0, ac, av);
                OP_ADC:         res = add32(a, op2, cin, ac, av);
                OP_SBC:         res = add32(a, ~op2, cin, ac, av);
                OP_RSC:         res = add32(op2, ~a, cin, ac, av);
                OP_ORR:         begin res = a | op2; logic_op = 1'b1; end
                OP_MOV:         begin res = op2; logic_op = 1'b1; end
                OP_BIC:         begin res = a & ~op2; logic_op = 1'b1; end
                default:        begin res = ~op2; logic_op = 1'b1; end
            endcase
            r.op_class = CLS_DATA;
            r.result_value = res;
            r.writes_result = !(op >= OP_TST && op <= OP_CMN);
            if (ir[20]) begin
                if (logic_op)
                    nf = {res[31], res == 32'h0, sc, f[0]};
                else
                    nf = {res[31], res == 32'h0, ac, av};
            end
        end else begin
            r.op_class = CLS_BRANCH;
        end
        if (!passed) begin
            r.writes_result = 1'b0;
            nf = f;
        end
        nzcv = nf;
        r.cond_passed = passed;
        r.flags_out = nf;
        return r;
    endfunction

    function automatic logic [11:0] sh_imm(input logic [4:0] amt, input logic [1:0] kind);
        logic [3:0] rm;
        rm = 4'($urandom);
        return {amt, kind, 1'b0, rm};
    endfunction

    function automatic logic [11:0] sh_reg(input logic [1:0] kind);
        logic [7:0] regs;
        regs = 8'($urandom);
        return {regs[7:4], 1'b0, kind, 1'b1, regs[3:0]};
    endfunction

    function automatic logic [31:0] dp_word(input logic [3:0] cc, input logic imm,
                                            input logic [3:0] op, input logic s,
                                            input logic [11:0] op2);
        logic [7:0] regs;
        regs = 8'($urandom);
        return {cc, DP_TAG, imm, op, s, regs, op2};
    endfunction

    function automatic logic [31:0] mul_word(input logic [3:0] cc, input logic acc,
                                             input logic s);
        logic [15:0] regs;
        regs = 16'($urandom);
        return {cc, 6'b000000, acc, s, regs[11:0], MUL_TAG, regs[15:12]};
    endfunction

    function automatic logic [31:0] mem_word(input logic [3:0] cc, input logic reg_off,
                                             input logic pre, input logic up,
                                             input logic [11:0] off);
        logic [10:0] bits;
        bits = 11'($urandom);
        return {cc, MEM_TAG, reg_off, pre, up, bits, off};
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_shift_source();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(1) == 0)
            r[7:0] = 8'($urandom_range(40));
        return r;
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        logic [3:0]  cc;
        logic [4:0]  amt;
        logic [1:0]  kind;
        logic [11:0] op2;
        int          sel;
        w = $urandom;
        cc = 4'($urandom);
        amt = 5'($urandom);
        kind = 2'($urandom);
        op2 = 12'($urandom);
        if ($urandom_range(2) != 0)
            cc = COND_AL;
        sel = $urandom_range(99);
        if (sel < 40) begin
            if ($urandom_range(2) == 0)
                amt = '0;
            case ($urandom_range(2))
                0: w = dp_word(cc, 1'b1, w[24:21], w[20], op2);
                1: w = dp_word(cc, 1'b0, w[24:21], w[20], sh_imm(amt, kind));
                default: w = dp_word(cc, 1'b0, w[24:21], w[20], sh_reg(kind));
            endcase
        end else if (sel < 55) begin
            w = mul_word(cc, w[21], w[20]);
        end else if (sel < 75) begin
            w[31:28] = cc;
            w[27:26] = MEM_TAG;
            if ($urandom_range(2) == 0)
                w[11:7] = '0;
        end else if (sel < 82) begin
            w[31:28] = cc;
            w[27:25] = BR_TAG;
        end else if (sel < 88) begin
            w[31:28] = cc;
            if (w[0])
                w[27:25] = BLOCK_TAG;
            else
                w[27:26] = COPROC_TAG;
        end
        return w;
    endfunction

    task automatic send_item(input logic [31:0] ir, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_instruction <= ir;
        i_value_bits_19_16 <= a;
        i_value_bits_15_12 <= b;
        i_value_bits_11_8 <= c;
        i_value_bits_3_0 <= d;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_execute(ir, a, b, c, d));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [31:0] w;
        send_idle_pct = 0;
        stall_pct = 0;
        send_item(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, {4'd0, 8'h00}), '1, 0, 0, 0);
        send_item(dp_word(COND_AL, 1'b0, OP_AND, 1'b1, sh_imm(5'd0, SHIFT_LSL)),
                  32'h0F0F_0F0F, 0, 0, '1);
        send_item(dp_word(COND_AL, 1'b0, OP_EOR, 1'b1, sh_imm(5'd0, SHIFT_LSR)),
                  32'h8000_0000, 0, 0, 32'h8000_0000);
        send_item(dp_word(COND_AL, 1'b0, OP_SUB, 1'b1, sh_imm(5'd0, SHIFT_ASR)),
                  0, 0, 0, 32'h8000_0000);
        send_item(dp_word(COND_AL, 1'b0, OP_RSB, 1'b1, sh_imm(5'd0, SHIFT_ROR)),
                  32'h1234_5678, 0, 0, 1);
        send_item(dp_word(COND_AL, 1'b1, OP_ADD, 1'b1, {4'd0, 8'd1}), 32'h7FFF_FFFF, 0, 0, 0);
        send_item(dp_word(COND_AL, 1'b0, OP_ADC, 1'b1, sh_reg(SHIFT_LSL)),
                  '1, 0, 32'hFFFF_FF20, '1);
        send_item(dp_word(COND_AL, 1'b0, OP_SBC, 1'b1, sh_reg(SHIFT_LSR)),
                  32'h0000_0010, 0, 32'd40, '1);
        send_item(dp_word(COND_AL, 1'b0, OP_RSC, 1'b1, sh_reg(SHIFT_ASR)),
                  0, 0, 32'd255, 32'h8000_0000);
        send_item(dp_word(COND_AL, 1'b0, OP_TST, 1'b1, sh_reg(SHIFT_ROR)),
                  '1, 0, 32'd32, 32'h8000_0001);
        send_item(dp_word(COND_AL, 1'b0, OP_TEQ, 1'b1, sh_reg(SHIFT_ROR)),
                  32'h5555_5555, 0, 32'hFFFF_FF00, 32'hAAAA_AAAA);
        send_item(dp_word(COND_AL, 1'b1, OP_CMP, 1'b1, {4'd0, 8'd5}), 32'd5, 0, 0, 0);
        send_item(dp_word(COND_AL, 1'b1, OP_CMN, 1'b1, {4'd0, 8'd1}), '1, 0, 0, 0);
        send_item(dp_word(COND_AL, 1'b1, OP_ORR, 1'b1, {4'd15, 8'hFF}), 0, 0, 0, 0);
        send_item(dp_word(COND_AL, 1'b0, OP_BIC, 1'b1, sh_imm(5'd31, SHIFT_LSL)), '1, 0, 0, 1);
        send_item(dp_word(COND_AL, 1'b1, OP_MVN, 1'b1, {4'd0, 8'h00}), 0, 0, 0, 0);
        send_item(dp_word(COND_PL, 1'b1, OP_ADD, 1'b1, {4'd0, 8'd7}), 32'd9, 0, 0, 0);
        send_item(dp_word(COND_NV, 1'b1, OP_MOV, 1'b1, {4'd0, 8'h00}), 0, 0, 0, 0);
        send_item(mul_word(COND_AL, 1'b0, 1'b1), 0, 0, '1, '1);
        send_item(mul_word(COND_AL, 1'b1, 1'b1), 0, 0, 32'h0001_0000, 32'h0001_0000);
        send_item(mem_word(COND_AL, 1'b0, 1'b1, 1'b1, 12'hFFF), '1, '1, 0, 0);
        send_item(mem_word(COND_AL, 1'b1, 1'b0, 1'b0, sh_imm(5'd0, SHIFT_ROR)),
                  32'h100, 0, 0, 32'd3);
        w = $urandom;
        w[31:28] = COND_AL;
        w[27:25] = BR_TAG;
        send_item(w, pick_operand(), pick_operand(), pick_operand(), pick_operand());
        w[27:25] = BLOCK_TAG;
        send_item(w, pick_operand(), pick_operand(), pick_operand(), pick_operand());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 66; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 66; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            repeat (95)
                send_item(random_instruction(), pick_operand(), pick_operand(),
                          pick_shift_source(), pick_operand());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        repeat (40)
            send_item(random_instruction(), pick_operand(), pick_operand(),
                      pick_shift_source(), pick_operand());
        wait_drained();
    endtask

    // hold off for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_exec_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual result %h",
                         $time, o_result_value);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_value", want.result_value, o_result_value);
                check_field("updated_base", want.updated_base, o_updated_base);
                check_field("op_class", 32'(want.op_class), 32'(o_op_class));
                check_field("cond_passed", 32'(want.cond_passed), 32'(o_cond_passed));
                check_field("writes_result", 32'(want.writes_result), 32'(o_writes_result));
                check_field("flags_out", 32'(want.flags_out), 32'(o_flags_out));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        nzcv = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
